// File: sv/fbu_pkg.sv
// Shared types, register codes and channel expansion functions for the framebuffer unpacker.
package fbu_pkg;

  // Configuration register field widths
  localparam int CFG_FMT_W    = 3;
  localparam int CFG_DIM_W    = 13;
  localparam int CFG_STRIDE_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd240;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd400;

  // Source pixel formats; the remaining codes decode to opaque black
  typedef enum logic [CFG_FMT_W-1:0] {
    FMT_RGBA8  = 3'd0,
    FMT_RGB8   = 3'd1,
    FMT_RGB565 = 3'd2,
    FMT_RGB5A1 = 3'd3,
    FMT_RGBA4  = 3'd4
  } fmt_t;

  // Configuration register set
  typedef struct packed {
    logic [CFG_FMT_W-1:0]    pixel_format;
    logic [CFG_DIM_W-1:0]    frame_width;
    logic [CFG_DIM_W-1:0]    frame_height;
    logic [CFG_STRIDE_W-1:0] row_stride;
  } cfg_t;

  // Per-byte status from the scan controller
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } scan_status_t;

  // One converted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // floor(x*255/31) = 8x + floor(7x/31); the second term by threshold compares
  function automatic logic [7:0] expand5(logic [4:0] x);
    logic [2:0] k;
    k = 3'(x >= 5'd5) + 3'(x >= 5'd9) + 3'(x >= 5'd14) + 3'(x >= 5'd18)
      + 3'(x >= 5'd23) + 3'(x >= 5'd27) + 3'(x >= 5'd31);
    return {x, 3'b000} + {5'd0, k};
  endfunction

  // floor(x*255/63) = 4x + floor(x/21)
  function automatic logic [7:0] expand6(logic [5:0] x);
    logic [1:0] k;
    k = 2'(x >= 6'd21) + 2'(x >= 6'd42) + 2'(x >= 6'd63);
    return {x, 2'b00} + {6'd0, k};
  endfunction

  // x*17 is the nibble repeated
  function automatic logic [7:0] expand4(logic [3:0] x);
    return {x, x};
  endfunction

endpackage

// File: sv/fbu_pixel_expand.sv
// Format decode: turns the gathered source bytes of one pixel into RGBA8888.
module fbu_pixel_expand
  import fbu_pkg::*;
(
  input  logic [CFG_FMT_W-1:0] pixel_format,
  input  logic [7:0]           byte0,
  input  logic [7:0]           byte1,
  input  logic [7:0]           byte2,
  input  logic [7:0]           last_byte,
  output pixel_t               pixel
);

  logic [15:0] word;

  // Two-byte formats are little-endian: the closing byte is the high half
  assign word = {last_byte, byte0};

  always_comb begin
    pixel = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF};
    unique case (pixel_format)
      FMT_RGBA8: begin
        pixel = '{red: byte0, green: byte1, blue: byte2, alpha: last_byte};
      end
      FMT_RGB8: begin
        pixel = '{red: byte0, green: byte1, blue: last_byte, alpha: 8'hFF};
      end
      FMT_RGB565: begin
        pixel.red   = expand5(word[15:11]);
        pixel.green = expand6(word[10:5]);
        pixel.blue  = expand5(word[4:0]);
        pixel.alpha = 8'hFF;
      end
      FMT_RGB5A1: begin
        pixel.red   = expand5(word[15:11]);
        pixel.green = expand5(word[10:6]);
        pixel.blue  = expand5(word[5:1]);
        pixel.alpha = word[0] ? 8'hFF : 8'h00;
      end
      FMT_RGBA4: begin
        pixel.red   = expand4(word[15:12]);
        pixel.green = expand4(word[11:8]);
        pixel.blue  = expand4(word[7:4]);
        pixel.alpha = expand4(word[3:0]);
      end
      default: begin
        // unassigned codes: opaque black
        pixel = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF};
      end
    endcase
  end

endmodule

// File: sv/fbu_scan_ctrl.sv
// Scan position tracking: byte phase, held bytes, column, row and byte position in the row.
module fbu_scan_ctrl
  import fbu_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   source_byte,
  input  cfg_t         cfg,
  output scan_status_t status,
  output logic [7:0]   byte0,
  output logic [7:0]   byte1,
  output logic [7:0]   byte2
);

  // Longest possible row in bytes, either from the stride register or 4 bytes a pixel
  localparam int STRIDE_MAX = (4 * MAX_DIM > 65535) ? 4 * MAX_DIM : 65535;
  localparam int PW = $clog2(STRIDE_MAX + 1);
  localparam int RW = $clog2(MAX_DIM + 1);
  localparam int XW = (RW > CFG_DIM_W) ? RW : CFG_DIM_W;

  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    held0_r, held0_nxt;
  logic [7:0]    held1_r, held1_nxt;
  logic [7:0]    held2_r, held2_nxt;
  logic [PW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic [2:0]    bpp;
  logic [XW-1:0] width_x, height_x;
  logic [RW-1:0] width_c, height_c;
  logic [PW-1:0] width_p;
  logic [PW-1:0] active;
  logic [PW-1:0] stride_cfg;
  logic [PW-1:0] stride;
  logic [PW-1:0] pos_inc;
  logic          in_active;
  logic          complete;
  logic          last_col;
  logic          last_row;
  logic          line_done;

  // Effective frame geometry from the registers
  always_comb begin
    unique case (cfg.pixel_format)
      FMT_RGBA8: bpp = 3'd4;
      FMT_RGB8:  bpp = 3'd3;
      default:   bpp = 3'd2;
    endcase

    width_x  = XW'(cfg.frame_width);
    height_x = XW'(cfg.frame_height);
    if (width_x == '0) begin
      width_c = RW'(1);
    end else if (width_x > XW'(MAX_DIM)) begin
      width_c = RW'(MAX_DIM);
    end else begin
      width_c = width_x[RW-1:0];
    end
    if (height_x == '0) begin
      height_c = RW'(1);
    end else if (height_x > XW'(MAX_DIM)) begin
      height_c = RW'(MAX_DIM);
    end else begin
      height_c = height_x[RW-1:0];
    end

    width_p = PW'(width_c);
    unique case (bpp)
      3'd4:    active = width_p << 2;
      3'd3:    active = (width_p << 1) + width_p;
      default: active = width_p << 1;
    endcase

    // short strides (zero too) are raised to the active row length
    stride_cfg = PW'(cfg.row_stride);
    stride     = (stride_cfg < active) ? active : stride_cfg;
  end

  // Per-byte decisions
  assign in_active = pos_r < active;
  assign complete  = in_active && (({1'b0, phase_r} + 3'd1) >= bpp);
  assign last_col  = ((PW + 1)'(col_r) + 1'b1) >= (PW + 1)'(width_c);
  assign last_row  = ((RW + 1)'(row_r) + 1'b1) >= (RW + 1)'(height_c);
  assign pos_inc   = pos_r + 1'b1;
  assign line_done = pos_inc >= stride;

  assign status.emit      = complete;
  assign status.row_end   = last_col;
  assign status.frame_end = last_col && last_row;
  assign byte0 = held0_r;
  assign byte1 = held1_r;
  assign byte2 = held2_r;

  // Next state for one consumed byte
  always_comb begin
    phase_nxt = phase_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    held2_nxt = held2_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pos_nxt   = pos_r;

    if (step) begin
      if (in_active) begin
        if (complete) begin
          phase_nxt = 2'd0;
          held0_nxt = 8'd0;
          held1_nxt = 8'd0;
          held2_nxt = 8'd0;
          col_nxt   = col_r + 1'b1;
        end else begin
          case (phase_r)
            2'd0:    held0_nxt = source_byte;
            2'd1:    held1_nxt = source_byte;
            2'd2:    held2_nxt = source_byte;
            default: ;
          endcase
          phase_nxt = phase_r + 2'd1;
        end
      end

      // end of row, padding included
      if (line_done) begin
        pos_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = 2'd0;
        held0_nxt = 8'd0;
        held1_nxt = 8'd0;
        held2_nxt = 8'd0;
        row_nxt   = last_row ? '0 : row_r + 1'b1;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      held0_r <= 8'd0;
      held1_r <= 8'd0;
      held2_r <= 8'd0;
      col_r   <= '0;
      row_r   <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// File: sv/framebuffer_to_rgba8888_unpacker.sv
// Top level of the framebuffer to RGBA8888 unpacker: config registers and pipeline registers.
//
// Usage:
//   Source bytes of a linear framebuffer enter on the in_ channel (valid/ready), one byte
//   per transaction, row after row. Each completed source pixel leaves as one RGBA8888
//   transaction on the out_ channel with row_end / frame_end flags; bytes that only
//   gather part of a pixel, and row padding up to the stride, give no output.
//   The cfg_ port writes pixel_format, frame_width, frame_height and row_stride
//   (index 0..3); writes take effect at once and belong between frames.
// Timing:
//   A byte is captured in the input register, decoded in one pass and the pixel lands
//   in the output register once the output slot is free.
//   One byte per cycle is sustained while out_ready stays high; the scan counters update
//   in the same single pass, so back-to-back bytes stream without bubbles.
// Reset (synchronous, rst_n low): registers take their defaults (RGBA8, 240 x 400,
//   stride 0), the scan position returns to the first byte of the frame and both
//   pipeline registers empty.
// Stall: while out_ready is low a pending pixel holds; one more byte waits in the input
//   register, then in_ready drops until the output is taken.
module framebuffer_to_rgba8888_unpacker
  import fbu_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // source bytes
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_source_byte,
  // converted pixels
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic [7:0]             out_alpha,
  output logic                   out_row_end,
  output logic                   out_frame_end
);

  cfg_t         cfg_r;
  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_fire;
  logic         out_valid_r, out_valid_nxt;
  pixel_t       pix_r;
  logic         row_end_r;
  logic         frame_end_r;
  scan_status_t status;
  logic [7:0]   byte0, byte1, byte2;
  pixel_t       pixel;

  // Configuration register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format <= FMT_RGBA8;
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
      cfg_r.row_stride   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: cfg_r.pixel_format <= cfg_data[CFG_FMT_W-1:0];
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[CFG_DIM_W-1:0];
        REG_ROW_STRIDE:   cfg_r.row_stride   <= cfg_data[CFG_STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the input stage moves on whenever the output slot is free
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = s1_fire ? status.emit : (out_valid_r && !out_ready);
  end

  fbu_scan_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_fire),
    .source_byte (s1_byte_r),
    .cfg         (cfg_r),
    .status      (status),
    .byte0       (byte0),
    .byte1       (byte1),
    .byte2       (byte2)
  );

  fbu_pixel_expand u_expand (
    .pixel_format (cfg_r.pixel_format),
    .byte0        (byte0),
    .byte1        (byte1),
    .byte2        (byte2),
    .last_byte    (s1_byte_r),
    .pixel        (pixel)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_source_byte;
    end
    if (s1_fire && status.emit) begin
      pix_r       <= pixel;
      row_end_r   <= status.row_end;
      frame_end_r <= status.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = pix_r.red;
  assign out_green     = pix_r.green;
  assign out_blue      = pix_r.blue;
  assign out_alpha     = pix_r.alpha;
  assign out_row_end   = row_end_r;
  assign out_frame_end = frame_end_r;

endmodule
